// ===== rtl/core/efr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  localparam int unsigned MaxFrameDef = 2048;
  localparam int unsigned MaxFrameRegW = 12;
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] RegEndChar = 3'd0;
  localparam logic [CfgAddrW-1:0] RegEscapeChar = 3'd1;
  localparam logic [CfgAddrW-1:0] RegCrcPoly = 3'd2;
  localparam logic [CfgAddrW-1:0] RegTimeoutTicks = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMaxFrame = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StCrc = 3'd1;
  localparam logic [2:0] StShort = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StTimeout = 3'd4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcGood = 16'h0000;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_ESC,
    KIND_END,
    KIND_DATA
  } kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [10:0] frame_length;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
  } mid_t;

  typedef struct packed {
    logic [7:0]              end_char;
    logic [7:0]              escape_char;
    logic [15:0]             crc_poly;
    logic [15:0]             timeout_ticks;
    logic [MaxFrameRegW-1:0] max_frame;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/escaped_frame_receiver_crc16_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Escape-stuffed frame receiver with CRC-16 check. Push received bytes and
// time ticks on the input queue; pop payload bytes and one end-of-frame
// status per frame from the result queue. One item is taken every clock
// cycle, sustained while results are popped as they appear: the back end
// does the whole byte step, including the eight-bit CRC update, in
// combinational logic. When the result queue fills, the back end holds and
// the input queue fills behind it. Each result is registered in the result
// queue before it shows on the result ports. Write the configuration
// registers only while the block has nothing in flight.
module escaped_frame_receiver_crc16_top #(
  parameter int unsigned MAX_FRAME = efr_pkg::MaxFrameDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire efr_pkg::in_t                   in_i,
  output logic                                empty,
  input  wire logic                           pop,
  output efr_pkg::out_t                       out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [efr_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [efr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  efr_pkg::cfg_t cfg_q;
  efr_pkg::mid_t front_entry;
  efr_pkg::mid_t mid_entry;
  efr_pkg::out_t res;
  logic          front_valid, front_ready, mid_full, mid_empty, mid_pop;
  logic          res_push, res_full;
  logic [$bits(efr_pkg::mid_t)-1:0] mid_rdata;
  logic [$bits(efr_pkg::out_t)-1:0] out_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_char      <= 8'hC0;
      cfg_q.escape_char   <= 8'hDB;
      cfg_q.crc_poly      <= 16'h1021;
      cfg_q.timeout_ticks <= 16'd5000;
      cfg_q.max_frame     <= efr_pkg::MaxFrameRegW'(efr_pkg::MaxFrameDef);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        efr_pkg::RegEndChar:      cfg_q.end_char      <= cfg_wdata_i[7:0];
        efr_pkg::RegEscapeChar:   cfg_q.escape_char   <= cfg_wdata_i[7:0];
        efr_pkg::RegCrcPoly:      cfg_q.crc_poly      <= cfg_wdata_i;
        efr_pkg::RegTimeoutTicks: cfg_q.timeout_ticks <= cfg_wdata_i;
        efr_pkg::RegMaxFrame: begin
          cfg_q.max_frame <= cfg_wdata_i[efr_pkg::MaxFrameRegW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  efr_front u_front (
    .cfg_i   (cfg_q),
    .valid_i (push),
    .item_i  (in_i),
    .ready_o (front_ready),
    .valid_o (front_valid),
    .entry_o (front_entry),
    .ready_i (!mid_full)
  );

  assign full = !front_ready;

  efr_fifo #(
    .Width ($bits(efr_pkg::mid_t)),
    .Depth (efr_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_entry),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_entry = efr_pkg::mid_t'(mid_rdata);

  efr_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (!mid_empty),
    .entry_i    (mid_entry),
    .pop_o      (mid_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  efr_fifo #(
    .Width ($bits(efr_pkg::out_t)),
    .Depth (efr_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_o = efr_pkg::out_t'(out_rdata);

endmodule

`default_nettype wire

// ===== rtl/core/efr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efr_front (
  input  wire efr_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire efr_pkg::in_t  item_i,
  output logic               ready_o,
  output logic               valid_o,
  output efr_pkg::mid_t      entry_o,
  input  wire logic          ready_i
);

  assign ready_o = ready_i;
  assign valid_o = valid_i;

  always_comb begin
    entry_o.rx_byte = item_i.rx_byte;
    if (item_i.func) begin
      entry_o.kind = efr_pkg::KIND_TICK;
    end else if (item_i.rx_byte == cfg_i.escape_char) begin
      entry_o.kind = efr_pkg::KIND_ESC;
    end else if (item_i.rx_byte == cfg_i.end_char) begin
      entry_o.kind = efr_pkg::KIND_END;
    end else begin
      entry_o.kind = efr_pkg::KIND_DATA;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efr_back #(
  parameter int unsigned MAX_FRAME = efr_pkg::MaxFrameDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire efr_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire efr_pkg::mid_t entry_i,
  output logic               pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output efr_pkg::out_t      res_o
);

  localparam int unsigned FullW = $clog2(MAX_FRAME + 1);
  localparam int unsigned CntW =
    (FullW < efr_pkg::MaxFrameRegW) ? FullW : efr_pkg::MaxFrameRegW;

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     ticks_q, ticks_d;
  logic [7:0]      dly_q [2];
  logic [7:0]      dly_d [2];

  logic [CntW-1:0] lim;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     tlim;
  logic [15:0]     ticks_inc;
  logic [15:0]     crc_new;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  assign pop_o     = valid_i && !res_full_i;
  assign cnt_inc   = cnt_q + CntW'(1);
  assign tlim      = (cfg_i.timeout_ticks == '0) ? 16'd1 : cfg_i.timeout_ticks;
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign crc_new   = crc_byte(crc_q, entry_i.rx_byte, cfg_i.crc_poly);

  always_comb begin
    if (32'(cfg_i.max_frame) > MAX_FRAME) begin
      lim = CntW'(MAX_FRAME);
    end else if (cfg_i.max_frame == '0) begin
      lim = CntW'(1);
    end else begin
      lim = CntW'(cfg_i.max_frame);
    end
  end

  always_comb begin
    logic go_idle;
    logic literal;
    go_idle    = 1'b0;
    literal    = 1'b0;
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    ticks_d    = ticks_q;
    dly_d      = dly_q;
    res_push_o = 1'b0;
    res_o      = '0;

    if (pop_o) begin
      if (entry_i.kind == efr_pkg::KIND_TICK) begin
        if (in_frame_q) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= tlim) begin
            go_idle      = 1'b1;
            res_push_o   = 1'b1;
            res_o.is_status = 1'b1;
            res_o.status = efr_pkg::StTimeout;
          end
        end
      end else begin
        in_frame_d = 1'b1;
        ticks_d    = '0;
        if (esc_q) begin
          esc_d   = 1'b0;
          literal = 1'b1;
        end else begin
          case (entry_i.kind)
            efr_pkg::KIND_ESC: begin
              esc_d = 1'b1;
            end
            efr_pkg::KIND_END: begin
              go_idle         = 1'b1;
              res_push_o      = 1'b1;
              res_o.is_status = 1'b1;
              if (cnt_q < CntW'(2)) begin
                res_o.status = efr_pkg::StShort;
              end else if (crc_q != efr_pkg::CrcGood) begin
                res_o.status = efr_pkg::StCrc;
              end else begin
                res_o.status       = efr_pkg::StOk;
                res_o.frame_length = 11'(cnt_q - CntW'(2));
              end
            end
            default: begin
              literal = 1'b1;
            end
          endcase
        end

        if (literal) begin
          crc_d = crc_new;
          cnt_d = cnt_inc;
          if (cnt_q >= CntW'(2)) begin
            dly_d[0] = dly_q[1];
            dly_d[1] = entry_i.rx_byte;
            res_push_o      = 1'b1;
            res_o.data_byte = dly_q[0];
          end else begin
            dly_d[cnt_q[0]] = entry_i.rx_byte;
          end
          if (cnt_inc >= lim) begin
            go_idle         = 1'b1;
            res_push_o      = 1'b1;
            res_o           = '0;
            res_o.is_status = 1'b1;
            res_o.status    = efr_pkg::StOverflow;
          end
        end
      end

      if (go_idle) begin
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        crc_d      = efr_pkg::CrcInit;
        cnt_d      = '0;
        ticks_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      crc_q      <= efr_pkg::CrcInit;
      cnt_q      <= '0;
      ticks_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      crc_q      <= crc_d;
      cnt_q      <= cnt_d;
      ticks_q    <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q <= dly_d;
  end

endmodule

`default_nettype wire
